>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
// Needs signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define CHK_PROP(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every edge, reset included.
`define CHK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> sv/thas_pkg.sv
// Package for the terrain height/attribute sampler.
// Field widths, default parameter values, op codes and the command control struct.
`default_nettype none

package thas_pkg;

   localparam int GRID_SIZE_DEF   = 256;
   localparam int CELL_UNITS_DEF  = 100;
   localparam int HEIGHT_BITS_DEF = 16;
   localparam int QUEUE_DEPTH_DEF = 8;

   localparam int IDX_W      = 16;
   localparam int CELL_HGT_W = 16;
   localparam int BYTE_W     = 8;
   localparam int WORLD_W    = 18;
   localparam int FRAC_W     = 8;
   localparam int HGT_OUT_W  = 24;

   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 40;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef struct packed {
      op_type              op;
      logic                wr_ok;
      logic [FRAC_W-1:0]   frac_row;
      logic [FRAC_W-1:0]   frac_col;
      logic [BYTE_W-1:0]   attr;
      logic [BYTE_W-1:0]   layer;
   } cmd_ctl_type;

endpackage

`default_nettype wire

>>> sv/thas_queue.sv
// Small flop queue between the sampler front and back ends.
// Generic width; the producer never pushes into a full queue (credit kept upstream).
`default_nettype none

module thas_queue #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push_valid, pop})
         2'b10:   cnt_in = cnt_ff + CNT_W'(1);
         2'b01:   cnt_in = cnt_ff - CNT_W'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_valid = (cnt_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

endmodule

`default_nettype wire

>>> sv/thas_front.sv
// Front end: accepts request words, classifies load/query, derives cell, fraction,
// nearest cell and grid addresses over four stages. Uses thas_pkg.
`default_nettype none

module thas_front #(
   parameter int GRID_SIZE   = thas_pkg::GRID_SIZE_DEF,
   parameter int CELL_UNITS  = thas_pkg::CELL_UNITS_DEF,
   parameter int HEIGHT_BITS = thas_pkg::HEIGHT_BITS_DEF,
   parameter int QUEUE_DEPTH = thas_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   input  thas_pkg::op_type                              req_op,
   input  logic [thas_pkg::IDX_W-1:0]                    req_cell_index,
   input  logic [thas_pkg::CELL_HGT_W-1:0]               req_cell_height,
   input  logic [thas_pkg::BYTE_W-1:0]                   req_cell_attribute,
   input  logic [thas_pkg::BYTE_W-1:0]                   req_cell_layer,
   input  logic [thas_pkg::WORLD_W-1:0]                  req_world_x,
   input  logic [thas_pkg::WORLD_W-1:0]                  req_world_z,
   input  logic                                          cmd_pop,
   output logic                                          cmd_valid,
   output thas_pkg::cmd_ctl_type                         cmd_ctl,
   output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0]        cmd_addr,
   output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0]        cmd_near,
   output logic [HEIGHT_BITS-1:0]                        cmd_height
);

   import thas_pkg::*;

   localparam int CELLS = GRID_SIZE * GRID_SIZE;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(GRID_SIZE);
   localparam int PW    = 2 * CW + 1;
   localparam int WU_W  = WORLD_W - 1;
   localparam int CU_W  = $clog2(CELL_UNITS + 1);
   localparam int R_W   = (CELL_UNITS > 1) ? $clog2(CELL_UNITS) : 1;
   localparam int S1    = WU_W + $clog2(CELL_UNITS);
   localparam int M1_W  = WU_W + 2;
   localparam int P1_W  = WU_W + M1_W;
   localparam int N2    = R_W + FRAC_W;
   localparam int S2    = N2 + $clog2(CELL_UNITS);
   localparam int M2_W  = N2 + 2;
   localparam int P2_W  = N2 + M2_W;
   localparam int QC_W  = WU_W + CU_W;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [M1_W-1:0] M1 =
      M1_W'(((64'd1 << S1) + 64'(CELL_UNITS) - 64'd1) / 64'(CELL_UNITS));
   localparam logic [M2_W-1:0] M2 =
      M2_W'(((64'd1 << S2) + 64'(CELL_UNITS) - 64'd1) / 64'(CELL_UNITS));
   localparam logic [CU_W-1:0] CU_C     = CU_W'(CELL_UNITS);
   localparam logic [31:0]     TOP_C    = 32'((GRID_SIZE - 2) * CELL_UNITS);
   localparam logic [31:0]     CELLS_C  = 32'(CELLS);
   localparam logic [WU_W-1:0] Q_NEAR_C = WU_W'(GRID_SIZE - 1);
   localparam logic [CW-1:0]   CELL_MAX = CW'(GRID_SIZE - 2);
   localparam logic [CW-1:0]   NEAR_MAX = CW'(GRID_SIZE - 1);
   localparam logic [CW:0]     GRID_C   = (CW + 1)'(GRID_SIZE);

   // credit: words accepted and not yet popped from the queue
   logic             accept;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign req_tready = (cnt_ff < CNT_W'(QUEUE_DEPTH));
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      case ({accept, cmd_pop})
         2'b10:   cnt_in = cnt_ff + CNT_W'(1);
         2'b01:   cnt_in = cnt_ff - CNT_W'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   // stage a: reciprocal multiply for the cell quotient
   logic [WORLD_W-1:0] wld [2];
   logic [P1_W-1:0]    prod1 [2];

   logic                va_ff, va_in;
   op_type              op_a_ff, op_a_in;
   logic                wr_a_ff, wr_a_in;
   logic [AW-1:0]       addr_a_ff, addr_a_in;
   logic [HEIGHT_BITS-1:0] hgt_a_ff, hgt_a_in;
   logic [BYTE_W-1:0]   attr_a_ff, attr_a_in;
   logic [BYTE_W-1:0]   layer_a_ff, layer_a_in;
   logic                neg_a_ff [2], neg_a_in [2];
   logic [WU_W-1:0]     wu_a_ff [2], wu_a_in [2];
   logic [WU_W-1:0]     q_a_ff [2], q_a_in [2];

   assign wld[0] = req_world_x;
   assign wld[1] = req_world_z;

   always_comb begin
      va_in      = accept;
      op_a_in    = req_op;
      wr_a_in    = (32'(req_cell_index) < CELLS_C);
      addr_a_in  = AW'(req_cell_index);
      hgt_a_in   = HEIGHT_BITS'(req_cell_height);
      attr_a_in  = req_cell_attribute;
      layer_a_in = req_cell_layer;
      for (int i = 0; i < 2; i++) begin
         neg_a_in[i] = wld[i][WORLD_W-1];
         wu_a_in[i]  = wld[i][WU_W-1:0];
         prod1[i]    = P1_W'(wld[i][WU_W-1:0]) * P1_W'(M1);
         q_a_in[i]   = WU_W'(prod1[i] >> S1);
      end
   end

   // stage b: remainder, clamping decisions
   logic [QC_W-1:0]     qc [2];

   logic                vb_ff;
   op_type              op_b_ff;
   logic                wr_b_ff;
   logic [AW-1:0]       addr_b_ff;
   logic [HEIGHT_BITS-1:0] hgt_b_ff;
   logic [BYTE_W-1:0]   attr_b_ff, layer_b_ff;
   logic [R_W-1:0]      r_b_ff [2], r_b_in [2];
   logic                zf_b_ff [2], zf_b_in [2];
   logic [CW-1:0]       cell_b_ff [2], cell_b_in [2];
   logic [CW-1:0]       near_b_ff [2], near_b_in [2];

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         qc[i]     = QC_W'(q_a_ff[i]) * QC_W'(CU_C);
         r_b_in[i] = R_W'(QC_W'(wu_a_ff[i]) - qc[i]);
         zf_b_in[i] = neg_a_ff[i] || (32'(wu_a_ff[i]) >= TOP_C);
         if (neg_a_ff[i]) begin
            cell_b_in[i] = '0;
         end else if (32'(wu_a_ff[i]) >= TOP_C) begin
            cell_b_in[i] = CELL_MAX;
         end else begin
            cell_b_in[i] = CW'(q_a_ff[i]);
         end
         if (neg_a_ff[i]) begin
            near_b_in[i] = '0;
         end else if (q_a_ff[i] > Q_NEAR_C) begin
            near_b_in[i] = NEAR_MAX;
         end else begin
            near_b_in[i] = CW'(q_a_ff[i]);
         end
      end
   end

   // stage c: 8-bit fraction by reciprocal multiply
   logic [P2_W-1:0]     prod2 [2];

   logic                vc_ff;
   op_type              op_c_ff;
   logic                wr_c_ff;
   logic [AW-1:0]       addr_c_ff;
   logic [HEIGHT_BITS-1:0] hgt_c_ff;
   logic [BYTE_W-1:0]   attr_c_ff, layer_c_ff;
   logic [FRAC_W-1:0]   frac_c_ff [2], frac_c_in [2];
   logic [CW-1:0]       cell_c_ff [2], near_c_ff [2];

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         prod2[i]     = P2_W'({r_b_ff[i], {FRAC_W{1'b0}}}) * P2_W'(M2);
         frac_c_in[i] = zf_b_ff[i] ? '0 : FRAC_W'(prod2[i] >> S2);
      end
   end

   // stage d: linear grid addresses
   logic                vd_ff;
   cmd_ctl_type         ctl_d_ff, ctl_d_in;
   logic [AW-1:0]       addr_d_ff, addr_d_in;
   logic [AW-1:0]       near_d_ff, near_d_in;
   logic [HEIGHT_BITS-1:0] hgt_d_ff;
   logic [AW-1:0]       base;

   always_comb begin
      base      = AW'(PW'(cell_c_ff[0]) * PW'(GRID_C)) + AW'(cell_c_ff[1]);
      near_d_in = AW'(PW'(near_c_ff[0]) * PW'(GRID_C)) + AW'(near_c_ff[1]);
      addr_d_in = (op_c_ff == OP_QUERY) ? base : addr_c_ff;
      ctl_d_in.op       = op_c_ff;
      ctl_d_in.wr_ok    = wr_c_ff;
      ctl_d_in.frac_row = frac_c_ff[0];
      ctl_d_in.frac_col = frac_c_ff[1];
      ctl_d_in.attr     = attr_c_ff;
      ctl_d_in.layer    = layer_c_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         va_ff  <= 1'b0;
         vb_ff  <= 1'b0;
         vc_ff  <= 1'b0;
         vd_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         va_ff  <= va_in;
         vb_ff  <= va_ff;
         vc_ff  <= vb_ff;
         vd_ff  <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      op_a_ff    <= op_a_in;
      wr_a_ff    <= wr_a_in;
      addr_a_ff  <= addr_a_in;
      hgt_a_ff   <= hgt_a_in;
      attr_a_ff  <= attr_a_in;
      layer_a_ff <= layer_a_in;
      op_b_ff    <= op_a_ff;
      wr_b_ff    <= wr_a_ff;
      addr_b_ff  <= addr_a_ff;
      hgt_b_ff   <= hgt_a_ff;
      attr_b_ff  <= attr_a_ff;
      layer_b_ff <= layer_a_ff;
      op_c_ff    <= op_b_ff;
      wr_c_ff    <= wr_b_ff;
      addr_c_ff  <= addr_b_ff;
      hgt_c_ff   <= hgt_b_ff;
      attr_c_ff  <= attr_b_ff;
      layer_c_ff <= layer_b_ff;
      ctl_d_ff   <= ctl_d_in;
      addr_d_ff  <= addr_d_in;
      near_d_ff  <= near_d_in;
      hgt_d_ff   <= hgt_c_ff;
      for (int i = 0; i < 2; i++) begin
         neg_a_ff[i]  <= neg_a_in[i];
         wu_a_ff[i]   <= wu_a_in[i];
         q_a_ff[i]    <= q_a_in[i];
         r_b_ff[i]    <= r_b_in[i];
         zf_b_ff[i]   <= zf_b_in[i];
         cell_b_ff[i] <= cell_b_in[i];
         near_b_ff[i] <= near_b_in[i];
         frac_c_ff[i] <= frac_c_in[i];
         cell_c_ff[i] <= cell_b_ff[i];
         near_c_ff[i] <= near_b_ff[i];
      end
   end

   assign cmd_valid  = vd_ff;
   assign cmd_ctl    = ctl_d_ff;
   assign cmd_addr   = addr_d_ff;
   assign cmd_near   = near_d_ff;
   assign cmd_height = hgt_d_ff;

endmodule

`default_nettype wire

>>> sv/thas_back.sv
// Back end: grid memories (two height copies with two read ports each, one
// attribute/layer store), bilinear blend and output register. Uses thas_pkg.
`default_nettype none

module thas_back #(
   parameter int GRID_SIZE   = thas_pkg::GRID_SIZE_DEF,
   parameter int HEIGHT_BITS = thas_pkg::HEIGHT_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_we,
   input  logic                                     csr_wdata,
   input  logic                                     cmd_valid,
   output logic                                     cmd_pop,
   input  thas_pkg::cmd_ctl_type                    cmd_ctl,
   input  logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0]   cmd_addr,
   input  logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0]   cmd_near,
   input  logic [HEIGHT_BITS-1:0]                   cmd_height,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [thas_pkg::HGT_OUT_W-1:0]           rsp_height,
   output logic [thas_pkg::BYTE_W-1:0]              rsp_attribute,
   output logic [thas_pkg::BYTE_W-1:0]              rsp_layer
);

   import thas_pkg::*;

   localparam int CELLS = GRID_SIZE * GRID_SIZE;
   localparam int AW    = $clog2(CELLS);
   localparam int W9    = FRAC_W + 1;
   localparam int RS_W  = HEIGHT_BITS + FRAC_W;
   localparam int SUM_W = HEIGHT_BITS + 2 * FRAC_W;
   localparam logic [W9-1:0] ONE_W = W9'(1 << FRAC_W);
   localparam logic [AW-1:0] ROW_STEP = AW'(GRID_SIZE);

   logic map_present_ff, map_present_in;
   logic en, is_query, wr;
   logic [AW-1:0] a01, a10, a11;

   assign map_present_in = csr_we ? csr_wdata : map_present_ff;
   assign en       = !rsp_tvalid || rsp_tready;
   assign cmd_pop  = en && cmd_valid;
   assign is_query = (cmd_ctl.op == OP_QUERY);
   assign wr       = cmd_pop && !is_query && cmd_ctl.wr_ok;
   assign a01      = cmd_addr + AW'(1);
   assign a10      = cmd_addr + ROW_STEP;
   assign a11      = a10 + AW'(1);

   // stage 1: memory access
   logic [HEIGHT_BITS-1:0] hgt_r0_mem [CELLS];
   logic [HEIGHT_BITS-1:0] hgt_r1_mem [CELLS];
   logic [2*BYTE_W-1:0]    al_mem [CELLS];

   logic                   v1_ff, v1_in;
   logic [HEIGHT_BITS-1:0] h00_ff, h01_ff, h10_ff, h11_ff;
   logic [2*BYTE_W-1:0]    al1_ff;
   logic [FRAC_W-1:0]      cf1_ff, rf1_ff;

   assign v1_in = en ? (cmd_valid && is_query) : v1_ff;

   always_ff @(posedge clock) begin
      if (wr) begin
         hgt_r0_mem[cmd_addr] <= cmd_height;
         hgt_r1_mem[cmd_addr] <= cmd_height;
         al_mem[cmd_addr]     <= {cmd_ctl.attr, cmd_ctl.layer};
      end
      if (en) begin
         h00_ff <= hgt_r0_mem[cmd_addr];
         h01_ff <= hgt_r0_mem[a01];
         h10_ff <= hgt_r1_mem[a10];
         h11_ff <= hgt_r1_mem[a11];
         al1_ff <= al_mem[cmd_near];
         cf1_ff <= cmd_ctl.frac_col;
         rf1_ff <= cmd_ctl.frac_row;
      end
   end

   // stage 2: blend along the column axis, one per row
   logic                v2_ff, v2_in;
   logic [RS_W-1:0]     top_ff, top_in, bot_ff, bot_in;
   logic [FRAC_W-1:0]   rf2_ff;
   logic [2*BYTE_W-1:0] al2_ff;
   logic [W9-1:0]       wc0, wc1;

   assign v2_in  = en ? v1_ff : v2_ff;
   assign wc1    = W9'(cf1_ff);
   assign wc0    = ONE_W - wc1;
   assign top_in = RS_W'(h00_ff) * RS_W'(wc0) + RS_W'(h01_ff) * RS_W'(wc1);
   assign bot_in = RS_W'(h10_ff) * RS_W'(wc0) + RS_W'(h11_ff) * RS_W'(wc1);

   always_ff @(posedge clock) begin
      if (en) begin
         top_ff <= top_in;
         bot_ff <= bot_in;
         rf2_ff <= rf1_ff;
         al2_ff <= al1_ff;
      end
   end

   // stage 3: blend along the row axis into the output register
   logic                 out_valid_ff, out_valid_in;
   logic [HGT_OUT_W-1:0] out_hgt_ff, out_hgt_in;
   logic [BYTE_W-1:0]    out_attr_ff, out_attr_in, out_layer_ff, out_layer_in;
   logic [SUM_W-1:0]     sum;
   logic [W9-1:0]        wr0, wr1;

   assign out_valid_in = en ? v2_ff : out_valid_ff;
   assign wr1 = W9'(rf2_ff);
   assign wr0 = ONE_W - wr1;
   assign sum = SUM_W'(top_ff) * SUM_W'(wr0) + SUM_W'(bot_ff) * SUM_W'(wr1);

   always_comb begin
      if (map_present_ff) begin
         out_hgt_in   = HGT_OUT_W'(sum >> FRAC_W);
         out_attr_in  = al2_ff[2*BYTE_W-1:BYTE_W];
         out_layer_in = al2_ff[BYTE_W-1:0];
      end else begin
         out_hgt_in   = '0;
         out_attr_in  = '0;
         out_layer_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_hgt_ff   <= out_hgt_in;
         out_attr_ff  <= out_attr_in;
         out_layer_ff <= out_layer_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_present_ff <= 1'b0;
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         map_present_ff <= map_present_in;
         v1_ff          <= v1_in;
         v2_ff          <= v2_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   assign rsp_tvalid    = out_valid_ff;
   assign rsp_height    = out_hgt_ff;
   assign rsp_attribute = out_attr_ff;
   assign rsp_layer     = out_layer_ff;

endmodule

`default_nettype wire

>>> sv/terrain_height_attribute_sampler_core.sv
// Top level of the terrain height/attribute sampler: front end, command queue, back end.
// Depends on thas_pkg, thas_front, thas_queue and thas_back.
//
// channel  dir  handshake               payload
// req      in   req_tvalid/req_tready   tdata, tuser = op (0 load, 1 query)
// rsp      out  rsp_tvalid/rsp_tready   tdata
// csr      in   csr_we                  csr_wdata = map_present
//
// One word per cycle unless the back end is frozen; each height copy serves two reads per word.
// A query passes front stages a to d, the queue, then back stages 1 to 3 to rsp_tvalid; loads give none.
// Reset clears control only; grid cells are undefined until loaded.
// rsp_tready low with rsp_tvalid high freezes the back end; the front keeps filling the
// queue and req_tready drops once QUEUE_DEPTH words are in flight ahead of the back end.
`default_nettype none

module terrain_height_attribute_sampler_core #(
   parameter int GRID_SIZE   = thas_pkg::GRID_SIZE_DEF,
   parameter int CELL_UNITS  = thas_pkg::CELL_UNITS_DEF,
   parameter int HEIGHT_BITS = thas_pkg::HEIGHT_BITS_DEF,
   parameter int QUEUE_DEPTH = thas_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // cell_index, cell_height, cell_attribute, cell_layer, world_x, world_z, zero pad
   input  logic [thas_pkg::REQ_DATA_W-1:0]   req_tdata,
   // op
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // height_interp, attribute, layer
   output logic [thas_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_we,
   input  logic                              csr_wdata
);

   import thas_pkg::*;

   localparam int AW    = $clog2(GRID_SIZE * GRID_SIZE);
   localparam int CTL_W = $bits(cmd_ctl_type);
   localparam int Q_W   = CTL_W + 2 * AW + HEIGHT_BITS;

   logic                   f_valid, q_valid, pop;
   cmd_ctl_type            f_ctl, q_ctl;
   logic [AW-1:0]          f_addr, f_near, q_addr, q_near;
   logic [HEIGHT_BITS-1:0] f_height, q_height;
   logic [Q_W-1:0]         q_data;
   logic [HGT_OUT_W-1:0]   out_height;
   logic [BYTE_W-1:0]      out_attr, out_layer;

   thas_front #(
      .GRID_SIZE   (GRID_SIZE),
      .CELL_UNITS  (CELL_UNITS),
      .HEIGHT_BITS (HEIGHT_BITS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_tvalid         (req_tvalid),
      .req_tready         (req_tready),
      .req_op             (op_type'(req_tuser)),
      .req_cell_index     (req_tdata[15:0]),
      .req_cell_height    (req_tdata[31:16]),
      .req_cell_attribute (req_tdata[39:32]),
      .req_cell_layer     (req_tdata[47:40]),
      .req_world_x        (req_tdata[65:48]),
      .req_world_z        (req_tdata[83:66]),
      .cmd_pop            (pop),
      .cmd_valid          (f_valid),
      .cmd_ctl            (f_ctl),
      .cmd_addr           (f_addr),
      .cmd_near           (f_near),
      .cmd_height         (f_height)
   );

   thas_queue #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (Q_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_data  ({f_ctl, f_addr, f_near, f_height}),
      .pop        (pop),
      .pop_valid  (q_valid),
      .pop_data   (q_data)
   );

   assign {q_ctl, q_addr, q_near, q_height} = q_data;

   thas_back #(
      .GRID_SIZE   (GRID_SIZE),
      .HEIGHT_BITS (HEIGHT_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .cmd_valid     (q_valid),
      .cmd_pop       (pop),
      .cmd_ctl       (q_ctl),
      .cmd_addr      (q_addr),
      .cmd_near      (q_near),
      .cmd_height    (q_height),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_height    (out_height),
      .rsp_attribute (out_attr),
      .rsp_layer     (out_layer)
   );

   assign rsp_tdata = {out_layer, out_attr, out_height};

endmodule

`default_nettype wire

>>> sv/thas_checker.sv
// Port-level checker for the terrain sampler top level, bound in below.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module thas_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        csr_we,
   input logic        csr_wdata
);

   logic       map_ff, map_in;
   logic       q_acc, r_acc;
   logic [7:0] pend_ff, pend_in;

   assign q_acc  = req_tvalid && req_tready && req_tuser;
   assign r_acc  = rsp_tvalid && rsp_tready;
   assign map_in = csr_we ? csr_wdata : map_ff;

   always_comb begin
      case ({q_acc, r_acc})
         2'b10:   pend_in = pend_ff + 8'd1;
         2'b01:   pend_in = pend_ff - 8'd1;
         default: pend_in = pend_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff  <= 1'b0;
         pend_ff <= '0;
      end else begin
         map_ff  <= map_in;
         pend_ff <= pend_in;
      end
   end

   `CHK_ALWAYS(a_reset_idle, reset |=> !rsp_tvalid, "result valid right after reset")
   `CHK_PROP(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   `CHK_PROP(a_no_orphan, rsp_tvalid |-> pend_ff != 8'd0, "result without an outstanding query")
   `CHK_PROP(a_absent_zero, rsp_tvalid && !map_ff |-> rsp_tdata == 40'd0, "nonzero result with map absent")

endmodule

bind terrain_height_attribute_sampler_core thas_checker u_thas_checker (.*);

`default_nettype wire
